// ----- hw/rtl/mbrb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mbrb_pkg;

    localparam int MAILBOX_COUNT = 16;
    localparam int ADDR_W        = 6;
    localparam int DATA_W        = 16;
    localparam int BYTE_W        = 8;

    localparam logic [ADDR_W-1:0] ADDR_MAP0 = 6'o40;
    localparam logic [ADDR_W-1:0] ADDR_MAP1 = 6'o42;
    localparam logic [ADDR_W-1:0] ADDR_MASK = 6'o44;
    localparam logic [ADDR_W-1:0] ADDR_KICK = 6'o46;
    localparam logic [ADDR_W-1:0] ADDR_ENB  = 6'o50;
    localparam logic [ADDR_W-1:0] ADDR_PID  = 6'o54;
    localparam logic [ADDR_W-1:0] ADDR_XMT  = 6'o62;
    localparam logic [ADDR_W-1:0] ADDR_RCV  = 6'o64;

endpackage

`default_nettype wire

// ----- hw/rtl/mbrb_mbox_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mbrb_mbox_store #(
    parameter int MAILBOX_COUNT = mbrb_pkg::MAILBOX_COUNT,
    parameter int IDX_W         = $clog2(MAILBOX_COUNT)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic                        i_wr_en,
    input  wire logic [IDX_W-1:0]            i_idx,
    input  wire logic [mbrb_pkg::DATA_W-1:0] i_wdata,
    output logic      [mbrb_pkg::DATA_W-1:0] o_rdata
);

    logic [mbrb_pkg::DATA_W-1:0] r_mem [MAILBOX_COUNT];
    logic [MAILBOX_COUNT-1:0]    r_vld;
    logic [mbrb_pkg::DATA_W-1:0] r_mem_q;
    logic                        r_vld_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_idx] <= i_wdata;
        end
        if (i_rd_en) begin
            r_mem_q <= r_mem[i_idx];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_q <= r_vld[i_idx];
            end
        end
    end

    assign o_rdata = r_vld_q ? r_mem_q : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/mailbox_register_block_top.sv -----
// An accepted transfer moves through the pending registers into the output registers;
// r_busy stalls the input after each accepted access, since the mailbox memory read is
// registered and the next access waits for it. A held output (i_stall) also stalls it.
// Reset: synchronous active-low i_rst_n clears the control registers, the busy flag, the
// mailbox valid bits and the output valid; mailboxes read as zero until written.
`timescale 1ns / 1ps
`default_nettype none

module mailbox_register_block_top #(
    parameter int MAILBOX_COUNT = mbrb_pkg::MAILBOX_COUNT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_opcode,
    input  wire logic                          i_byte_write,
    input  wire logic [mbrb_pkg::ADDR_W-1:0]   i_address,
    input  wire logic [mbrb_pkg::DATA_W-1:0]   i_write_data,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [mbrb_pkg::DATA_W-1:0]   o_read_data,
    output logic                               o_irq
);

    localparam int IDX_W = $clog2(MAILBOX_COUNT);
    localparam int AW    = mbrb_pkg::ADDR_W;
    localparam int DW    = mbrb_pkg::DATA_W;
    localparam int BW    = mbrb_pkg::BYTE_W;
    localparam logic [AW:0] MB_SPAN = (AW+1)'(2 * MAILBOX_COUNT);

    logic          w_acc;
    logic          w_mb_hit;
    logic [IDX_W-1:0] w_idx;
    logic [DW-1:0] w_mb_rdata;

    logic [DW-1:0] r_map0, r_map1, r_mask, r_enb, r_pid, r_xmt, r_rcv;
    logic [DW-1:0] n_map0, n_map1, n_mask, n_enb, n_pid, n_xmt, n_rcv;
    logic [DW-1:0] n_rd;

    logic          r_busy;
    logic          r_pend_mb;
    logic [DW-1:0] r_pend_rd;
    logic          r_pend_irq;

    logic          r_out_valid;
    logic [DW-1:0] r_out_rd;
    logic          r_out_irq;

    assign o_stall = r_busy || (r_out_valid && i_stall);
    assign w_acc   = i_valid && !o_stall;

    assign w_mb_hit = !i_address[0] && ({1'b0, i_address} < MB_SPAN);
    assign w_idx    = i_address[IDX_W:1];

    always_comb begin
        n_map0 = r_map0;
        n_map1 = r_map1;
        n_mask = r_mask;
        n_enb  = r_enb;
        n_pid  = r_pid;
        n_xmt  = r_xmt;
        n_rcv  = r_rcv;
        n_rd   = '0;
        if (w_mb_hit) begin
            if (i_opcode) begin
                n_xmt = r_xmt | (DW'(1) << w_idx);
            end else begin
                n_xmt = r_xmt & ~(DW'(1) << w_idx);
            end
        end else begin
            case (i_address)
                mbrb_pkg::ADDR_MAP0: begin
                    if (i_opcode) begin
                        n_map0[BW-1:0] = i_write_data[BW-1:0];
                        if (!i_byte_write) begin
                            n_map0[DW-1:BW] = i_write_data[DW-1:BW];
                        end
                    end else begin
                        n_rd = r_map0;
                    end
                end
                mbrb_pkg::ADDR_MAP1: begin
                    if (i_opcode) begin
                        n_map1[BW-1:0] = i_write_data[BW-1:0];
                        if (!i_byte_write) begin
                            n_map1[DW-1:BW] = i_write_data[DW-1:BW];
                        end
                    end else begin
                        n_rd = r_map1;
                    end
                end
                mbrb_pkg::ADDR_MASK: begin
                    if (i_opcode) n_mask = i_write_data; else n_rd = r_mask;
                end
                mbrb_pkg::ADDR_KICK: begin
                    n_rd = '0;
                end
                mbrb_pkg::ADDR_ENB: begin
                    if (i_opcode) n_enb = i_write_data; else n_rd = r_enb;
                end
                mbrb_pkg::ADDR_PID: begin
                    if (i_opcode) n_pid = i_write_data; else n_rd = r_pid;
                end
                mbrb_pkg::ADDR_XMT: begin
                    if (i_opcode) n_xmt = i_write_data; else n_rd = r_xmt;
                end
                mbrb_pkg::ADDR_RCV: begin
                    if (i_opcode) n_rcv = i_write_data; else n_rd = r_rcv;
                end
                default: begin
                    n_rd = '0;
                end
            endcase
        end
    end

    mbrb_mbox_store #(
        .MAILBOX_COUNT (MAILBOX_COUNT),
        .IDX_W         (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (w_acc && w_mb_hit && !i_opcode),
        .i_wr_en (w_acc && w_mb_hit && i_opcode),
        .i_idx   (w_idx),
        .i_wdata (i_write_data),
        .o_rdata (w_mb_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map0      <= '0;
            r_map1      <= '0;
            r_mask      <= '0;
            r_enb       <= '0;
            r_pid       <= '0;
            r_xmt       <= '0;
            r_rcv       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_map0 <= n_map0;
                r_map1 <= n_map1;
                r_mask <= n_mask;
                r_enb  <= n_enb;
                r_pid  <= n_pid;
                r_xmt  <= n_xmt;
                r_rcv  <= n_rcv;
            end
            r_busy <= w_acc;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pend_mb  <= w_mb_hit && !i_opcode;
            r_pend_rd  <= n_rd;
            r_pend_irq <= |(n_xmt & n_mask);
        end
        if (r_busy) begin
            r_out_rd  <= r_pend_mb ? w_mb_rdata : r_pend_rd;
            r_out_irq <= r_pend_irq;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_rd;
    assign o_irq       = r_out_irq;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam logic OP_READ    = 1'b0;
    localparam logic OP_WRITE   = 1'b1;
    localparam int   IDLE_LIMIT = 5000;
    localparam int   N_RANDOM   = 525;
    localparam int   QUIET_TAIL = 60;
    localparam int   HOLD_AT    = 100;
    localparam int   HOLD_LEN   = 120;

    typedef struct {
        logic                        op;
        logic                        bw;
        logic [mbrb_pkg::ADDR_W-1:0] addr;
        logic [mbrb_pkg::DATA_W-1:0] data;
        bit                          drain;
    } t_access;

    typedef struct {
        logic [mbrb_pkg::DATA_W-1:0] rd;
        logic                        irq;
    } t_resp;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_valid      = 1'b0;
    logic                        i_opcode     = 1'b0;
    logic                        i_byte_write = 1'b0;
    logic [mbrb_pkg::ADDR_W-1:0] i_address    = '0;
    logic [mbrb_pkg::DATA_W-1:0] i_write_data = '0;
    logic                        i_stall      = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [mbrb_pkg::DATA_W-1:0] o_read_data;
    logic                        o_irq;

    t_access access_q[$];
    t_resp   expected_resp[$];

    logic [mbrb_pkg::DATA_W-1:0] mbox [mbrb_pkg::MAILBOX_COUNT];
    logic [mbrb_pkg::BYTE_W-1:0] map_b [4];
    logic [mbrb_pkg::DATA_W-1:0] mask_r, enb_r, pid_r, xmt_r, rcv_r;

    int  n_accepted  = 0;
    int  n_results   = 0;
    int  n_errors    = 0;
    int  total_items = 1 << 30;
    int  send_gap    = 0;
    int  stall_gap   = 0;
    int  hold_cnt    = 0;
    int  idle_cnt    = 0;
    bit  held        = 0;

    mailbox_register_block_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_byte_write (i_byte_write),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_irq        (o_irq)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit quiet_phase();
        return n_accepted >= total_items - QUIET_TAIL;
    endfunction

    function void model_access(input logic op, input logic bw,
                               input logic [mbrb_pkg::ADDR_W-1:0] a,
                               input logic [mbrb_pkg::DATA_W-1:0] d, output t_resp r);
        logic [3:0] idx;
        logic [1:0] base;
        idx  = a[4:1];
        base = {a[1], 1'b0};
        r.rd = '0;
        if (a[0] == 1'b0 && a < 2 * mbrb_pkg::MAILBOX_COUNT) begin
            if (op == OP_WRITE) begin
                mbox[idx]  = d;
                xmt_r[idx] = 1'b1;
            end else begin
                r.rd       = mbox[idx];
                xmt_r[idx] = 1'b0;
            end
        end else if (a == mbrb_pkg::ADDR_MAP0 || a == mbrb_pkg::ADDR_MAP1) begin
            if (op == OP_WRITE) begin
                if (bw) begin
                    map_b[a[1:0]] = d[7:0];
                end else begin
                    map_b[base]      = d[7:0];
                    map_b[base + 1]  = d[15:8];
                end
            end else begin
                r.rd = {map_b[base + 1], map_b[base]};
            end
        end else if (a == mbrb_pkg::ADDR_MASK) begin
            if (op == OP_WRITE) mask_r = d; else r.rd = mask_r;
        end else if (a == mbrb_pkg::ADDR_ENB) begin
            if (op == OP_WRITE) enb_r = d; else r.rd = enb_r;
        end else if (a == mbrb_pkg::ADDR_PID) begin
            if (op == OP_WRITE) pid_r = d; else r.rd = pid_r;
        end else if (a == mbrb_pkg::ADDR_XMT) begin
            if (op == OP_WRITE) xmt_r = d; else r.rd = xmt_r;
        end else if (a == mbrb_pkg::ADDR_RCV) begin
            if (op == OP_WRITE) rcv_r = d; else r.rd = rcv_r;
        end
        r.irq = (xmt_r & mask_r) != '0;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [mbrb_pkg::DATA_W-1:0] got,
                                   input logic [mbrb_pkg::DATA_W-1:0] want);
        $display("MISMATCH %s at result %0d: got %h, expected %h", what, n_results, got, want);
        n_errors++;
    endtask

    task automatic add_access(input logic op, input logic bw,
                              input logic [mbrb_pkg::ADDR_W-1:0] a,
                              input logic [mbrb_pkg::DATA_W-1:0] d, input bit drain = 0);
        t_access it;
        it.op    = op;
        it.bw    = bw;
        it.addr  = a;
        it.data  = d;
        it.drain = drain;
        access_q.push_back(it);
    endtask

    // driver
    always @(posedge i_clk) begin : drv
        t_resp r;
        if (!i_rst_n) begin
            for (int k = 0; k < mbrb_pkg::MAILBOX_COUNT; k++) mbox[k] = '0;
            for (int k = 0; k < 4; k++) map_b[k] = '0;
            mask_r = '0;
            enb_r  = '0;
            pid_r  = '0;
            xmt_r  = '0;
            rcv_r  = '0;
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                model_access(i_opcode, i_byte_write, i_address, i_write_data, r);
                expected_resp.push_back(r);
                void'(access_q.pop_front());
                n_accepted++;
            end
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (access_q.size() == 0 ||
                             (access_q[0].drain && expected_resp.size() != 0)) begin
                    i_valid <= 1'b0;
                end else if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    i_valid <= 1'b0;
                end else begin
                    i_valid      <= 1'b1;
                    i_opcode     <= access_q[0].op;
                    i_byte_write <= access_q[0].bw;
                    i_address    <= access_q[0].addr;
                    i_write_data <= access_q[0].data;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_resp want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (expected_resp.size() == 0) begin
                    report_mismatch("result with no pending transfer", o_read_data, '0);
                end else begin
                    want = expected_resp.pop_front();
                    if (o_read_data !== want.rd)
                        report_mismatch("read_data", o_read_data, want.rd);
                    if (o_irq !== want.irq)
                        report_mismatch("irq", {15'd0, o_irq}, {15'd0, want.irq});
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else if (!held && n_results >= HOLD_AT) begin
                held     = 1;
                hold_cnt = HOLD_LEN - 1;
                i_stall <= 1'b1;
            end else if (stall_gap > 0) begin
                stall_gap--;
                i_stall <= 1'b1;
            end else if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
                stall_gap = $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cnt <= 0;
            end else if (idle_cnt >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cnt <= idle_cnt + 1;
            end
        end
    end

    initial begin : stim
        logic [mbrb_pkg::ADDR_W-1:0] a;
        logic [mbrb_pkg::DATA_W-1:0] d;
        int                          r;
        // directed
        add_access(OP_READ,  1'b0, 6'o00, 16'h0000);
        add_access(OP_WRITE, 1'b0, 6'o00, 16'hFFFF);
        add_access(OP_WRITE, 1'b1, 6'o36, 16'h0000);
        add_access(OP_WRITE, 1'b0, mbrb_pkg::ADDR_MASK, 16'hFFFF);
        add_access(OP_READ,  1'b0, mbrb_pkg::ADDR_XMT, 16'h0000);
        add_access(OP_READ,  1'b0, 6'o00, 16'h0000);
        add_access(OP_READ,  1'b0, 6'o36, 16'h0000);
        add_access(OP_WRITE, 1'b0, mbrb_pkg::ADDR_MAP0, 16'hA55A);
        add_access(OP_WRITE, 1'b0, mbrb_pkg::ADDR_MAP1, 16'hFFFF);
        add_access(OP_WRITE, 1'b1, mbrb_pkg::ADDR_MAP1, 16'hFF3C);
        add_access(OP_WRITE, 1'b1, 6'o41, 16'h1234);
        add_access(OP_READ,  1'b0, mbrb_pkg::ADDR_MAP0, 16'h0000);
        add_access(OP_READ,  1'b0, mbrb_pkg::ADDR_MAP1, 16'h0000);
        add_access(OP_WRITE, 1'b0, mbrb_pkg::ADDR_KICK, 16'hFFFF);
        add_access(OP_READ,  1'b0, mbrb_pkg::ADDR_KICK, 16'h0000);
        add_access(OP_WRITE, 1'b1, mbrb_pkg::ADDR_ENB, 16'hFFFF);
        add_access(OP_WRITE, 1'b0, mbrb_pkg::ADDR_PID, 16'h8001);
        add_access(OP_WRITE, 1'b0, mbrb_pkg::ADDR_RCV, 16'h7FFE);
        add_access(OP_WRITE, 1'b0, 6'o52, 16'hFFFF);
        add_access(OP_WRITE, 1'b0, 6'o77, 16'hFFFF);
        add_access(OP_READ,  1'b0, 6'o60, 16'h0000);
        add_access(OP_READ,  1'b0, 6'o03, 16'h0000);
        add_access(OP_WRITE, 1'b0, mbrb_pkg::ADDR_XMT, 16'h0000);
        add_access(OP_READ,  1'b0, mbrb_pkg::ADDR_ENB, 16'h0000);
        add_access(OP_READ,  1'b0, mbrb_pkg::ADDR_RCV, 16'h0000);
        // random
        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                a = 6'($urandom_range(0, mbrb_pkg::MAILBOX_COUNT - 1) * 2);
            end else if (r < 80) begin
                case ($urandom_range(0, 7))
                    0: a = mbrb_pkg::ADDR_MAP0;
                    1: a = mbrb_pkg::ADDR_MAP1;
                    2: a = mbrb_pkg::ADDR_MASK;
                    3: a = mbrb_pkg::ADDR_KICK;
                    4: a = mbrb_pkg::ADDR_ENB;
                    5: a = mbrb_pkg::ADDR_PID;
                    6: a = mbrb_pkg::ADDR_XMT;
                    default: a = mbrb_pkg::ADDR_RCV;
                endcase
            end else begin
                a = 6'($urandom_range(0, 63));
            end
            r = $urandom_range(0, 9);
            d = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            add_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), a, d,
                       n == 200 || n == 420);
        end
        total_items = access_q.size();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (access_q.size() != 0 || expected_resp.size() != 0);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/mbrb_pkg.sv
hw/rtl/mbrb_mbox_store.sv
hw/rtl/mailbox_register_block_top.sv
test/tb_top.sv
